// File: hw/rtl/hsw_pkg.sv
// ---------------------------------------------------------------------------
// hsw_pkg: shared types and constants of the heat stencil sweep unit
// Register map, fixed field widths, arithmetic constants and the control
// flags that travel with each request from the front to the back.
// ---------------------------------------------------------------------------
package hsw_pkg;

  localparam int GRID_W    = 11;
  localparam int BROW_W    = 10;
  localparam int ALPHA_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_LEN    = 2'd0,
    CFG_SPLIT_ROW   = 2'd1,
    CFG_ALPHA_UPPER = 2'd2,
    CFG_ALPHA_LOWER = 2'd3
  } cfg_reg_t;

  localparam logic [GRID_W-1:0]  SIDE_LEN_RST  = 11'd64;
  localparam logic [BROW_W-1:0]  SPLIT_ROW_RST = 10'd32;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd16384;

  localparam int GRID_MIN = 10;

  // Unity weight in Q1.15
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'h8000;

  // Result carries 17 fraction bits before rounding
  localparam int FRAC_SHIFT = 17;
  localparam int ROUND_HALF = 65536;

  // Entries of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic boundary;
    logic last;
  } hsw_flags_t;

endpackage

// File: hw/rtl/hsw_ram.sv
// ---------------------------------------------------------------------------
// hsw_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module hsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/hsw_front.sv
// ---------------------------------------------------------------------------
// hsw_front: raster tracking, line stores and operand gathering
// Accepts cells, tracks the grid position, reads the two line stores and
// pushes the operands and flags of every emitted cell into the queue.
// ---------------------------------------------------------------------------
module hsw_front import hsw_pkg::*; #(
  parameter int MAX_GRID   = 1024,
  parameter int TEMP_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [TEMP_WIDTH-1:0]        in_cell_temperature,
  input  logic [GRID_W-1:0]                   side_len,
  input  logic [BROW_W-1:0]                   split_row,
  input  logic [ALPHA_W-1:0]                  alpha_upper,
  input  logic [ALPHA_W-1:0]                  alpha_lower,
  input  logic [QCNT_W-1:0]                   q_count,
  output logic                                q_push,
  output logic [2*TEMP_WIDTH+2+ALPHA_W+$bits(hsw_flags_t)-1:0] q_push_data
);

  localparam int AW    = $clog2(MAX_GRID);
  localparam int NW    = $clog2(MAX_GRID + 1);
  localparam int EW    = (NW > GRID_W) ? NW : GRID_W;
  localparam int CW    = (AW > BROW_W) ? AW : BROW_W;
  localparam int SUM_W = TEMP_WIDTH + 2;

  logic [AW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [NW-1:0] n_eff, n_m1, col_inc, row_inc;
  logic [EW-1:0] gs_ext;
  logic          restart, col_wrap, row_wrap, accept;
  logic [AW-1:0] cur_row, cur_col, row_m1;
  logic [ALPHA_W-1:0] alpha_sel;
  hsw_flags_t    flags;

  // stage B: read data arrives, stores are updated
  logic                         b_valid_r, b_emit_r;
  logic [AW-1:0]                b_col_r;
  logic signed [TEMP_WIDTH-1:0] b_down_r;
  logic [ALPHA_W-1:0]           b_alpha_r;
  hsw_flags_t                   b_flags_r;
  logic signed [TEMP_WIDTH-1:0] left_r;

  logic [TEMP_WIDTH-1:0]        centre_raw, right_raw, up_raw;
  logic signed [TEMP_WIDTH-1:0] centre, right_v, up_v;
  logic signed [SUM_W-1:0]      sum;

  // effective side length, clamped into the supported range
  always_comb begin
    gs_ext = EW'(side_len);
    if (gs_ext < EW'(GRID_MIN)) begin
      n_eff = NW'(GRID_MIN);
    end else if (gs_ext > EW'(MAX_GRID)) begin
      n_eff = NW'(MAX_GRID);
    end else begin
      n_eff = NW'(gs_ext);
    end
  end

  assign n_m1    = n_eff - 1'b1;
  assign restart = (NW'(row_r) >= n_eff) || (NW'(col_r) >= n_eff);
  assign cur_row = restart ? '0 : row_r;
  assign cur_col = restart ? '0 : col_r;
  assign row_m1  = cur_row - 1'b1;

  assign col_inc  = NW'(cur_col) + 1'b1;
  assign row_inc  = NW'(cur_row) + 1'b1;
  assign col_wrap = col_inc >= n_eff;
  assign row_wrap = row_inc >= n_eff;

  // hold credit for the item in stage B so a push always finds room
  assign in_stall = (({1'b0, q_count} + (QCNT_W + 1)'(b_valid_r)) >=
                     (QCNT_W + 1)'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[AW-1:0];
      end else begin
        col_nxt = col_inc[AW-1:0];
        row_nxt = cur_row;
      end
    end
  end

  always_comb begin
    alpha_sel = (CW'(row_m1) < CW'(split_row)) ? alpha_upper : alpha_lower;
    if (alpha_sel > ALPHA_ONE) begin
      alpha_sel = ALPHA_ONE;
    end
    flags.boundary = (cur_row == AW'(1)) || (cur_col == '0) || (NW'(cur_col) == n_m1);
    flags.last     = (NW'(cur_row) == n_m1) && (NW'(cur_col) == n_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
      b_emit_r  <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      b_valid_r <= accept;
      b_emit_r  <= accept && (cur_row != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r   <= cur_col;
      b_down_r  <= in_cell_temperature;
      b_alpha_r <= alpha_sel;
      b_flags_r <= flags;
    end
    // left neighbor is the centre of the previous cell in the row
    if (b_valid_r) begin
      left_r <= centre;
    end
  end

  // previous row, two copies for the centre and right reads
  hsw_ram #(.WIDTH(TEMP_WIDTH), .DEPTH(MAX_GRID)) u_prev_c (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_col_r),
    .wdata (b_down_r),
    .re    (accept),
    .raddr (cur_col),
    .rdata (centre_raw)
  );

  hsw_ram #(.WIDTH(TEMP_WIDTH), .DEPTH(MAX_GRID)) u_prev_r (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_col_r),
    .wdata (b_down_r),
    .re    (accept),
    .raddr (cur_col + 1'b1),
    .rdata (right_raw)
  );

  hsw_ram #(.WIDTH(TEMP_WIDTH), .DEPTH(MAX_GRID)) u_second (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_col_r),
    .wdata (centre_raw),
    .re    (accept),
    .raddr (cur_col),
    .rdata (up_raw)
  );

  assign centre  = centre_raw;
  assign right_v = right_raw;
  assign up_v    = up_raw;

  assign sum = SUM_W'(up_v) + SUM_W'(left_r) + SUM_W'(right_v) + SUM_W'(b_down_r);

  assign q_push      = b_valid_r && b_emit_r;
  assign q_push_data = {centre, sum, b_alpha_r, b_flags_r};

endmodule

// File: hw/rtl/hsw_queue.sv
// ---------------------------------------------------------------------------
// hsw_queue: short request queue between front and back
// Register-based FIFO with an occupancy count for the front's credit check.
// ---------------------------------------------------------------------------
module hsw_queue import hsw_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  pop_data,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// File: hw/rtl/hsw_back.sv
// ---------------------------------------------------------------------------
// hsw_back: weighted stencil arithmetic and result register
// Multiplies both stencil terms, adds, rounds and saturates (boundary cells
// keep the centre) and holds the result in an output register until taken.
// ---------------------------------------------------------------------------
module hsw_back import hsw_pkg::*; #(
  parameter int TEMP_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [2*TEMP_WIDTH+2+ALPHA_W+$bits(hsw_flags_t)-1:0] q_pop_data,
  input  logic                                q_not_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [TEMP_WIDTH-1:0]        out_new_temperature,
  output logic                                out_sweep_last
);

  localparam int SUM_W = TEMP_WIDTH + 2;
  localparam int P1_W  = TEMP_WIDTH + ALPHA_W + 1;
  localparam int P2_W  = SUM_W + ALPHA_W + 1;
  localparam int VW    = TEMP_WIDTH + 21;
  localparam logic signed [VW-1:0] T_MAX = (VW'(1) <<< (TEMP_WIDTH - 1)) - VW'(1);
  localparam logic signed [VW-1:0] T_MIN = -T_MAX - VW'(1);

  logic signed [TEMP_WIDTH-1:0] q_centre;
  logic signed [SUM_W-1:0]      q_sum;
  logic [ALPHA_W-1:0]           q_alpha, one_minus;
  hsw_flags_t                   q_flags;
  logic signed [P1_W-1:0]       p1;
  logic signed [P2_W-1:0]       p2;

  logic                         m_valid_r;
  logic signed [P1_W-1:0]       m_p1_r;
  logic signed [P2_W-1:0]       m_p2_r;
  logic signed [TEMP_WIDTH-1:0] m_centre_r;
  hsw_flags_t                   m_flags_r;

  logic signed [VW-1:0]         v, q_shr;
  logic signed [TEMP_WIDTH-1:0] res;

  logic                         out_valid_r, out_last_r;
  logic signed [TEMP_WIDTH-1:0] out_temp_r;
  logic                         out_take, m_take;

  assign {q_centre, q_sum, q_alpha, q_flags} = q_pop_data;

  assign one_minus = ALPHA_ONE - q_alpha;
  assign p1 = q_centre * $signed({1'b0, one_minus});
  assign p2 = q_sum * $signed({1'b0, q_alpha});

  // advance the output register whenever it is empty or being taken
  assign out_take = !out_valid_r || !out_stall;
  assign m_take   = !m_valid_r || out_take;
  assign q_pop    = q_not_empty && m_take;

  always_comb begin
    v     = (VW'(m_p1_r) <<< 2) + VW'(m_p2_r) + VW'(ROUND_HALF);
    q_shr = v >>> FRAC_SHIFT;
    if (m_flags_r.boundary) begin
      res = m_centre_r;
    end else if (q_shr > T_MAX) begin
      res = T_MAX[TEMP_WIDTH-1:0];
    end else if (q_shr < T_MIN) begin
      res = T_MIN[TEMP_WIDTH-1:0];
    end else begin
      res = q_shr[TEMP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (m_take) begin
        m_valid_r <= q_pop;
      end
      if (out_take) begin
        out_valid_r <= m_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_p1_r     <= p1;
      m_p2_r     <= p2;
      m_centre_r <= q_centre;
      m_flags_r  <= q_flags;
    end
    if (out_take && m_valid_r) begin
      out_temp_r <= res;
      out_last_r <= m_flags_r.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_temperature = out_temp_r;
  assign out_sweep_last      = out_last_r;

endmodule

// File: hw/rtl/two_region_heat_stencil_sweep_unit.sv
// ---------------------------------------------------------------------------
// two_region_heat_stencil_sweep_unit: streaming five-point Jacobi sweep
// Cells pass stage B, the queue and the product register to the result.
// Throughput: one cell per cycle unless stalled, set by one store read per port.
// Up to QDEPTH + 2 results can be buffered while the output side stalls.
// Reset: positions, queue and pipeline control clear; registers take their
// reset values; line stores are not cleared and hold garbage until written.
// ---------------------------------------------------------------------------
module two_region_heat_stencil_sweep_unit import hsw_pkg::*; #(
  parameter int MAX_GRID   = 1024,
  parameter int TEMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [TEMP_WIDTH-1:0] in_cell_temperature,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [TEMP_WIDTH-1:0] out_new_temperature,
  output logic                         out_sweep_last
);

  localparam int QW = 2 * TEMP_WIDTH + 2 + ALPHA_W + $bits(hsw_flags_t);

  logic [GRID_W-1:0]  side_len_r;
  logic [BROW_W-1:0]  split_row_r;
  logic [ALPHA_W-1:0] alpha_upper_r, alpha_lower_r;

  logic              q_push, q_pop, q_not_empty;
  logic [QW-1:0]     q_push_data, q_pop_data;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_len_r    <= SIDE_LEN_RST;
      split_row_r   <= SPLIT_ROW_RST;
      alpha_upper_r <= ALPHA_RST;
      alpha_lower_r <= ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SIDE_LEN:    side_len_r    <= cfg_wdata[GRID_W-1:0];
        CFG_SPLIT_ROW:   split_row_r   <= cfg_wdata[BROW_W-1:0];
        CFG_ALPHA_UPPER: alpha_upper_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_ALPHA_LOWER: alpha_lower_r <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  hsw_front #(.MAX_GRID(MAX_GRID), .TEMP_WIDTH(TEMP_WIDTH)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cell_temperature (in_cell_temperature),
    .side_len            (side_len_r),
    .split_row           (split_row_r),
    .alpha_upper         (alpha_upper_r),
    .alpha_lower         (alpha_lower_r),
    .q_count             (q_count),
    .q_push              (q_push),
    .q_push_data         (q_push_data)
  );

  hsw_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  hsw_back #(.TEMP_WIDTH(TEMP_WIDTH)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_pop_data          (q_pop_data),
    .q_not_empty         (q_not_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_temperature (out_new_temperature),
    .out_sweep_last      (out_sweep_last)
  );

  // front credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != QCNT_W'(QDEPTH)))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("request popped from empty queue");

  // a full queue must hold off the input side
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == QCNT_W'(QDEPTH)) |-> in_stall)
    else $error("input accepted with full queue");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for two_region_heat_stencil_sweep_unit
// Streams grid cells in raster order through the valid/stall input channel.
// A behavioral line-store predictor queues the expected new temperatures.
// A monitor checks each result against that queue. Runs cover one directed
// sweep, a grid that shrinks mid-sweep, an oversized grid cut short, and
// random sweeps under two backpressure mixes.
// ---------------------------------------------------------------------------
module tb_top import hsw_pkg::*; ();

  localparam int MAX_GRID     = 1024;
  localparam int TEMP_W       = 16;
  localparam int MID_GRID     = 40;
  localparam int RANDOM_CELLS = 330;
  localparam int DRAIN_CYC    = 16;
  localparam int CYCLE_LIMIT  = 50000;

  typedef enum int {FIELD_NOISE, FIELD_SMOOTH, FIELD_EXTREME} field_style_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     last;
  } new_temp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_SIDE_LEN;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_cell_temperature = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] out_new_temperature;
  logic                     out_sweep_last;

  two_region_heat_stencil_sweep_unit #(
    .MAX_GRID  (MAX_GRID),
    .TEMP_WIDTH(TEMP_W)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_temperature(in_cell_temperature),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_new_temperature(out_new_temperature),
    .out_sweep_last     (out_sweep_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: line stores, raster position and register copies
  shortint           prev_row [MAX_GRID];
  shortint           second_row [MAX_GRID];
  int unsigned       row_pos = 0;
  int unsigned       col_pos = 0;
  logic [GRID_W-1:0]  grid_reg = SIDE_LEN_RST;
  logic [BROW_W-1:0]  brow_reg = SPLIT_ROW_RST;
  logic [ALPHA_W-1:0] alpha_up_reg = ALPHA_RST;
  logic [ALPHA_W-1:0] alpha_lo_reg = ALPHA_RST;

  logic signed [TEMP_W-1:0] cell_q[$];
  new_temp_t                new_temp_q[$];

  int  cells_pushed = 0;
  int  cells_accepted = 0;
  int  results_checked = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_accepted = 1'b0;

  function automatic int unsigned eff_grid();
    if (grid_reg < GRID_MIN) return GRID_MIN;
    if (grid_reg > MAX_GRID) return MAX_GRID;
    return grid_reg;
  endfunction

  // Compute the new value of the cell one row above x, then update the stores
  task automatic heat_predict(input logic signed [TEMP_W-1:0] x);
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int          a;
    longint      centre;
    longint      nsum;
    longint      acc;
    longint      r;
    new_temp_t   res;
    n = eff_grid();
    if (row_pos >= n || col_pos >= n) begin
      row_pos = 0;
      col_pos = 0;
    end
    i = row_pos;
    j = col_pos;
    if (i >= 1) begin
      centre = longint'(prev_row[j]);
      if (i == 1 || j == 0 || j == n - 1) begin
        r = centre;
      end else begin
        nsum = longint'(second_row[j]) + longint'(second_row[j-1])
             + longint'(prev_row[j+1]) + longint'(x);
        a = (i - 1 < brow_reg) ? int'(alpha_up_reg) : int'(alpha_lo_reg);
        if (a > int'(ALPHA_ONE)) a = int'(ALPHA_ONE);
        acc = longint'(4 * (int'(ALPHA_ONE) - a)) * centre + longint'(a) * nsum
            + ROUND_HALF;
        r = acc >>> FRAC_SHIFT;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
      end
      res.temp = r[TEMP_W-1:0];
      res.last = (i == n - 1 && j == n - 1);
      new_temp_q.push_back(res);
    end
    second_row[j] = prev_row[j];
    prev_row[j] = shortint'(x);
    col_pos = j + 1;
    if (col_pos >= n) begin
      col_pos = 0;
      row_pos = i + 1;
      if (row_pos >= n) row_pos = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Input driver: hold a stalled request, otherwise send the next cell or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (cell_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_cell_temperature <= cell_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_cell_temperature <= TEMP_W'($urandom);
      end
    end
    out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // Monitor: predict on every accepted cell, check every accepted result
  always @(posedge clk) begin
    new_temp_t exp_res;
    in_accepted = rst_n && in_valid && !in_stall;
    if (in_accepted) begin
      heat_predict(in_cell_temperature);
      cells_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (new_temp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_new_temperature));
      end else begin
        exp_res = new_temp_q.pop_front();
        results_checked++;
        if (out_new_temperature !== exp_res.temp)
          report_mismatch($sformatf("result %0d: new_temperature %0d, expected %0d",
                                    results_checked, out_new_temperature,
                                    $signed(exp_res.temp)));
        if (out_sweep_last !== exp_res.last)
          report_mismatch($sformatf("result %0d: sweep_last %0b, expected %0b",
                                    results_checked, out_sweep_last, exp_res.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_region_heat_stencil_sweep_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SIDE_LEN:    grid_reg = val[GRID_W-1:0];
      CFG_SPLIT_ROW:   brow_reg = val[BROW_W-1:0];
      CFG_ALPHA_UPPER: alpha_up_reg = val;
      default:         alpha_lo_reg = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sweep(input int grid, input int brow, input int aup, input int alo);
    write_reg(CFG_SIDE_LEN, CFG_W'(grid));
    write_reg(CFG_SPLIT_ROW, CFG_W'(brow));
    write_reg(CFG_ALPHA_UPPER, CFG_W'(aup));
    write_reg(CFG_ALPHA_LOWER, CFG_W'(alo));
  endtask

  task automatic push_cell(input logic signed [TEMP_W-1:0] v);
    cell_q.push_back(v);
    cells_pushed++;
  endtask

  // Drain: every cell taken, every result back, then let the pipeline settle
  task automatic wait_idle();
    while (cells_accepted != cells_pushed || new_temp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic logic signed [TEMP_W-1:0] sweep_cell(input field_style_t style,
                                                          input int base);
    int t;
    case (style)
      FIELD_NOISE: return TEMP_W'($urandom);
      FIELD_SMOOTH: begin
        t = base + int'($urandom_range(400, 0)) - 200;
        return TEMP_W'(t);
      end
      default: begin
        case ($urandom_range(3, 0))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  initial begin
    int           n;
    int           grid_val;
    int           brow_val;
    int           aup_val;
    int           alo_val;
    int           base;
    int           random_cells;
    int           sweeps_run;
    field_style_t style;

    random_cells = 0;
    sweeps_run = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 73;

    // Directed sweep: undersized grid clamps to 10, saturated upper weight,
    // zero lower weight, rails and -1/0 cycling, with rows 4 and 5 held at the rails
    set_sweep(0, 5, 16'hFFFF, 0);
    for (int r = 0; r < 10; r++) begin
      for (int c = 0; c < 10; c++) begin
        if (r == 4) push_cell(16'sh7FFF);
        else if (r == 5) push_cell(16'sh8000);
        else begin
          case ((r * 3 + c) % 4)
            0:       push_cell(16'sh7FFF);
            1:       push_cell(16'sh8000);
            2:       push_cell(16'sh0000);
            default: push_cell(-16'sd1);
          endcase
        end
      end
    end
    sweeps_run++;
    wait_idle();

    // Medium grid: three rows and a few cells, then shrink to 12 and finish
    // the sweep from the position already reached
    set_sweep(MID_GRID, 20, 0, 32768);
    repeat (3 * MID_GRID + 5) push_cell(sweep_cell(FIELD_NOISE, 0));
    wait_idle();
    write_reg(CFG_SIDE_LEN, 16'd12);
    repeat (12 * 12 - (3 * 12 + 5)) push_cell(sweep_cell(FIELD_NOISE, 0));
    sweeps_run++;
    wait_idle();

    // Oversized grid clamps to the maximum; shrink past the column restarts
    set_sweep(2047, 1, 32768, 1);
    repeat (60) push_cell(sweep_cell(FIELD_SMOOTH, 1000));
    wait_idle();
    set_sweep(10, 1023, 12345, 32768);
    repeat (100) push_cell(sweep_cell(FIELD_EXTREME, 0));
    sweeps_run++;
    wait_idle();

    // Random sweeps with fresh settings each time
    while (random_cells < RANDOM_CELLS) begin
      if (random_cells < RANDOM_CELLS / 2) begin
        send_idle_pct = 73;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(7, 0))
        0:       grid_val = $urandom_range(9, 0);
        1:       grid_val = 16;
        default: grid_val = $urandom_range(13, 10);
      endcase
      n = (grid_val < GRID_MIN) ? GRID_MIN : grid_val;
      if ($urandom_range(3, 0) == 0) brow_val = $urandom_range(1023, 0);
      else brow_val = $urandom_range(n - 1, 1);
      case ($urandom_range(4, 0))
        0:       aup_val = 0;
        1:       aup_val = 32768;
        2:       aup_val = $urandom_range(65535, 32769);
        default: aup_val = $urandom_range(32768, 0);
      endcase
      case ($urandom_range(4, 0))
        0:       alo_val = 0;
        1:       alo_val = 32768;
        2:       alo_val = $urandom_range(65535, 32769);
        default: alo_val = $urandom_range(32768, 0);
      endcase
      set_sweep(grid_val, brow_val, aup_val, alo_val);
      style = field_style_t'($urandom_range(2, 0));
      base = int'($urandom_range(60000, 0)) - 30000;
      repeat (n * n) push_cell(sweep_cell(style, base));
      random_cells += n * n;
      sweeps_run++;
      wait_idle();
    end

    $display("Ran %0d sweeps, %0d cells, clamped and shrunk grids included",
             sweeps_run, cells_accepted);
    $display("Checked %0d results under three backpressure mixes, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("two_region_heat_stencil_sweep_unit test passed");
    end else begin
      $display("two_region_heat_stencil_sweep_unit test failed");
    end
    $finish;
  end

endmodule
